>>> rtl/core/mfb_pkg.sv
// Shared types and constants of the monochrome frame-store draw engine.
`default_nettype none

package mfb_pkg;

  // Frame store geometry: 1024 bytes, one byte per column and page
  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam logic [2:0]  ROW_BITS    = 3'b111;

  // Request kinds
  localparam logic [1:0] REQ_LINE = 2'd0;
  localparam logic [1:0] REQ_RECT = 2'd1;
  localparam logic [1:0] REQ_FILL = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  // Store operation kinds
  typedef enum logic [1:0] {
    OP_RMW   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_kind_e;

  // One store operation issued by the sequencer
  typedef struct packed {
    logic              valid;
    op_kind_e          kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              color;
  } pix_op_t;

  // Store status back to the sequencer
  typedef struct packed {
    logic       ready;
    logic       rd_valid;
    logic [7:0] rd_data;
  } store_stat_t;

  // Finished result from the sequencer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mfb_if.sv
// Request and response channel interfaces of the draw engine.
`default_nettype none

interface mfb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] x_a;
  logic [5:0] y_a;
  logic [6:0] x_b;
  logic [5:0] y_b;
  logic [7:0] box_width;
  logic [6:0] box_height;
  logic       color;
  logic       fill_inside;
  logic [9:0] read_address;

  modport source (
    output valid, req_type, x_a, y_a, x_b, y_b, box_width, box_height,
           color, fill_inside, read_address,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_a, y_a, x_b, y_b, box_width, box_height,
           color, fill_inside, read_address,
    output ready
  );
endinterface

interface mfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mono_framebuffer_draw_engine.sv
// Flow: a read issues one store read and returns its byte; a line does one
//   read-modify-write per on-panel pixel; fill screen writes one byte per cycle.
// Rectangle: one read-modify-write per drawn pixel, off-panel ones only visited; empty: none.
// One request at a time; the single-port frame store read-modify-write sets the pace.
// Reset: asynchronous, active low; a clear pass then zeroes the frame store,
//   and no request is taken until it ends.
`default_nettype none

module mono_framebuffer_draw_engine #(
  parameter int unsigned PANEL_WIDTH = 128,
  parameter int unsigned PANEL_PAGES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfb_req_if.sink   req_i,
  mfb_rsp_if.source rsp_o
);

  mfb_pkg::pix_op_t     op;
  mfb_pkg::store_stat_t stat;
  mfb_pkg::result_t     res;
  logic                 res_ready;
  logic                 out_valid_q;
  logic [7:0]           out_data_q;

  mfb_seq #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_PAGES (PANEL_PAGES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .op_o        (op),
    .stat_i      (stat),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  mfb_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .stat_o (stat)
  );

  // Output word register
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/mfb_store.sv
// Frame store: 1024-byte memory with read-modify-write port and clear pass.
`default_nettype none

module mfb_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfb_pkg::pix_op_t     op_i,
  output mfb_pkg::store_stat_t stat_o
);

  logic [7:0]                 mem [mfb_pkg::STORE_DEPTH];
  logic [7:0]                 rd_q;
  logic                       clearing_q;
  logic [mfb_pkg::ADDR_W-1:0] clr_q;
  logic                       phase_q;
  mfb_pkg::op_kind_e          kind_q;
  logic [mfb_pkg::ADDR_W-1:0] addr_q;
  logic [7:0]                 mask_q;
  logic                       color_q;

  logic                       ready;
  logic                       take;
  logic                       re;
  logic                       we;
  logic [mfb_pkg::ADDR_W-1:0] waddr;
  logic [7:0]                 wdata;
  logic [7:0]                 merged;

  assign ready = !clearing_q && !phase_q;
  assign take  = ready && op_i.valid;
  assign re    = take && (op_i.kind != mfb_pkg::OP_WRITE);

  // Second half of a read-modify-write sets or clears the masked bit
  assign merged = color_q ? (rd_q | mask_q) : (rd_q & ~mask_q);

  // Write port select: clear pass, pending modify, or full-word write
  always_comb begin
    we    = 1'b0;
    waddr = op_i.addr;
    wdata = {8{op_i.color}};
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = 8'h00;
    end else if (phase_q) begin
      we    = (kind_q == mfb_pkg::OP_RMW);
      waddr = addr_q;
      wdata = merged;
    end else if (take && op_i.kind == mfb_pkg::OP_WRITE) begin
      we = 1'b1;
    end
  end

  // Memory array, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[op_i.addr];
    end
  end

  // Control: clear pass after reset, one-cycle modify phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      phase_q    <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      phase_q <= re;
    end
  end

  // Operation word held for the second phase
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q  <= op_i.kind;
      addr_q  <= op_i.addr;
      mask_q  <= op_i.mask;
      color_q <= op_i.color;
    end
  end

  assign stat_o.ready    = ready;
  assign stat_o.rd_valid = phase_q && (kind_q == mfb_pkg::OP_READ);
  assign stat_o.rd_data  = rd_q;

`ifndef NO_ASSERTIONS
  // The modify phase never lasts more than one cycle
  a_phase_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |=> !phase_q)
    else $error("store modify phase held for two cycles");

  // Clear pass only ends after the last entry was written
  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_q) == '1))
    else $error("clear pass ended early");

  // Read data is returned only for a read issued the cycle before
  a_rd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.rd_valid |-> $past(re && op_i.kind == mfb_pkg::OP_READ))
    else $error("read data without a read");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mfb_seq.sv
// Draw sequencer: steps lines, rectangles, screen fills and reads over the store.
`default_nettype none

module mfb_seq #(
  parameter int unsigned PANEL_WIDTH = 128,
  parameter int unsigned PANEL_PAGES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mfb_req_if.sink              req_i,
  output mfb_pkg::pix_op_t     op_o,
  input  mfb_pkg::store_stat_t stat_i,
  output mfb_pkg::result_t     res_o,
  input  logic                 res_ready_i
);

  localparam logic [8:0] XLim     = 9'(PANEL_WIDTH);
  localparam logic [8:0] XLast    = 9'(PANEL_WIDTH - 1);
  localparam logic [7:0] RowLim   = 8'(PANEL_PAGES * 8);
  localparam logic [7:0] PageLast = 8'(PANEL_PAGES - 1);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_LINE   = 8'b0000_0100,
    S_RECT   = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [8:0]        x_q, x_d, end_x_q, end_x_d, left_q, left_d;
  logic [7:0]        y_q, y_d, end_y_q, end_y_d, top_q, top_d;
  logic [6:0]        dx_q, dx_d, dy_q, dy_d;
  logic              sx_q, sx_d, sy_q, sy_d;
  logic signed [9:0] err_q, err_d;
  logic              color_q, color_d, solid_q, solid_d;
  logic [9:0]        rd_addr_q, rd_addr_d;
  logic [7:0]        res_q, res_d;

  logic               accept;
  logic               on_panel;
  logic               advance;
  logic               line_end;
  logic signed [10:0] e2, dx_s, dy_s, err_w;
  logic               step_x, step_y;
  logic               full_col, col_last;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Current pixel position checks
  assign on_panel = (x_q < XLim) && (y_q < RowLim);
  assign advance  = !op_o.valid || stat_i.ready;

  // Bresenham error terms
  assign dx_s     = $signed({4'b0, dx_q});
  assign dy_s     = $signed({4'b0, dy_q});
  assign e2       = $signed({err_q, 1'b0});
  assign step_x   = e2 > -dy_s;
  assign step_y   = e2 < dx_s;
  assign err_w    = $signed({err_q[9], err_q}) - (step_x ? dy_s : 11'sd0)
                    + (step_y ? dx_s : 11'sd0);
  assign line_end = (x_q == end_x_q) && (y_q == end_y_q);

  // Rectangle column walk: full columns at the edges or when solid
  assign full_col = solid_q || (x_q == left_q) || (x_q == end_x_q);
  assign col_last = (y_q == end_y_q) || (y_q >= RowLim);

  // Store operation for the current step
  always_comb begin
    op_o.valid = 1'b0;
    op_o.kind  = mfb_pkg::OP_RMW;
    op_o.addr  = {x_q[6:0], y_q[5:3]};
    op_o.mask  = 8'b1 << (y_q[2:0] & mfb_pkg::ROW_BITS);
    op_o.color = color_q;
    case (state_q)
      S_LINE, S_RECT: begin
        op_o.valid = on_panel;
      end
      S_FILL: begin
        op_o.valid = 1'b1;
        op_o.kind  = mfb_pkg::OP_WRITE;
        op_o.addr  = {x_q[6:0], y_q[2:0]};
        op_o.mask  = 8'hFF;
      end
      S_READ: begin
        op_o.valid = 1'b1;
        op_o.kind  = mfb_pkg::OP_READ;
        op_o.addr  = rd_addr_q;
      end
      default: begin
        op_o.valid = 1'b0;
      end
    endcase
  end

  // Next-state and datapath
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    end_x_d   = end_x_q;
    end_y_d   = end_y_q;
    left_d    = left_q;
    top_d     = top_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    err_d     = err_q;
    color_d   = color_q;
    solid_d   = solid_q;
    rd_addr_d = rd_addr_q;
    res_d     = res_q;
    case (state_q)
      S_INIT: begin
        if (stat_i.ready) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          color_d   = req_i.color;
          solid_d   = req_i.fill_inside;
          rd_addr_d = req_i.read_address;
          res_d     = 8'h00;
          x_d       = {2'b0, req_i.x_a};
          y_d       = {2'b0, req_i.y_a};
          left_d    = {2'b0, req_i.x_a};
          top_d     = {2'b0, req_i.y_a};
          case (req_i.req_type)
            mfb_pkg::REQ_LINE: begin
              end_x_d = {2'b0, req_i.x_b};
              end_y_d = {2'b0, req_i.y_b};
              dx_d    = (req_i.x_b > req_i.x_a) ? (req_i.x_b - req_i.x_a)
                                                : (req_i.x_a - req_i.x_b);
              dy_d    = (req_i.y_b > req_i.y_a) ? 7'(req_i.y_b - req_i.y_a)
                                                : 7'(req_i.y_a - req_i.y_b);
              sx_d    = req_i.x_a < req_i.x_b;
              sy_d    = req_i.y_a < req_i.y_b;
              err_d   = $signed({3'b0, dx_d}) - $signed({3'b0, dy_d});
              state_d = S_LINE;
            end
            mfb_pkg::REQ_RECT: begin
              end_x_d = {2'b0, req_i.x_a} + {1'b0, req_i.box_width} - 9'd1;
              end_y_d = {2'b0, req_i.y_a} + {1'b0, req_i.box_height} - 8'd1;
              if (req_i.box_width == '0 || req_i.box_height == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_RECT;
              end
            end
            mfb_pkg::REQ_FILL: begin
              x_d     = '0;
              y_d     = '0;
              state_d = S_FILL;
            end
            default: begin
              state_d = S_READ;
            end
          endcase
        end
      end
      S_LINE: begin
        if (advance) begin
          if (line_end) begin
            state_d = S_DONE;
          end else begin
            err_d = err_w[9:0];
            if (step_x) begin
              x_d = sx_q ? (x_q + 9'd1) : (x_q - 9'd1);
            end
            if (step_y) begin
              y_d = sy_q ? (y_q + 8'd1) : (y_q - 8'd1);
            end
          end
        end
      end
      S_RECT: begin
        if (advance) begin
          if (col_last) begin
            if (x_q == end_x_q || x_q >= XLast) begin
              state_d = S_DONE;
            end else begin
              x_d = x_q + 9'd1;
              y_d = top_q;
            end
          end else begin
            y_d = full_col ? (y_q + 8'd1) : end_y_q;
          end
        end
      end
      S_FILL: begin
        if (stat_i.ready) begin
          if (y_q == PageLast) begin
            y_d = '0;
            if (x_q == XLast) begin
              state_d = S_DONE;
            end else begin
              x_d = x_q + 9'd1;
            end
          end else begin
            y_d = y_q + 8'd1;
          end
        end
      end
      S_READ: begin
        if (stat_i.ready) begin
          state_d = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        if (stat_i.rd_valid) begin
          res_d   = stat_i.rd_data;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign res_o.valid = (state_q == S_DONE);
  assign res_o.data  = res_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    end_x_q   <= end_x_d;
    end_y_q   <= end_y_d;
    left_q    <= left_d;
    top_q     <= top_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    err_q     <= err_d;
    color_q   <= color_d;
    solid_q   <= solid_d;
    rd_addr_q <= rd_addr_d;
    res_q     <= res_d;
  end

endmodule

`default_nettype wire

>>> tb/tb_mono_framebuffer_draw_engine.sv
// Self-checking testbench for the monochrome frame-store draw engine.
`timescale 1ns / 1ps

module tb_mono_framebuffer_draw_engine;

  localparam int unsigned FB_COLS  = 128;
  localparam int unsigned FB_PAGES = 8;
  localparam int          RANDOM_REQS = 1800;
  localparam int          BIG_BOX_BUDGET = 8;
  localparam int          DRAIN_CYCLES = 50;

  // One request word as driven on the request channel
  typedef struct {
    logic [1:0] kind;
    logic [6:0] xa;
    logic [5:0] ya;
    logic [6:0] xb;
    logic [5:0] yb;
    logic [7:0] bw;
    logic [6:0] bh;
    logic       color;
    logic       solid;
    logic [9:0] addr;
  } draw_req_t;

  // Directed row: request plus an optional hand-written read_data
  typedef struct {
    draw_req_t  req;
    logic       fixed;
    logic [7:0] lit;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mfb_req_if req_bus ();
  mfb_rsp_if rsp_bus ();

  mono_framebuffer_draw_engine #(
    .PANEL_WIDTH(FB_COLS),
    .PANEL_PAGES(FB_PAGES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #10 clk_i = ~clk_i;

  // Shadow frame store and pending read_data words
  logic [7:0] frame_model [mfb_pkg::STORE_DEPTH];
  logic [7:0] pending_bytes [$];
  int         mismatch_count = 0;
  int         stall_left = 0;
  logic       steady_phase = 1'b0;
  int         big_boxes_left = BIG_BOX_BUDGET;
  int         last_x = 0;
  int         last_y = 0;

  // Directed requests: extremes, every request kind, the corner cases
  script_row_t script_rows [] = '{
    // reads straight after the clear pass
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 127, 63, 127, 63, 255, 127, 1, 1, 1023}, 1'b1, 8'h00},
    // whole-screen set and clear
    '{'{mfb_pkg::REQ_FILL, 0, 0, 0, 0, 0, 0, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 8'hFF},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023}, 1'b1, 8'hFF},
    '{'{mfb_pkg::REQ_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 8'h00},
    // single-point lines at opposite corners
    '{'{mfb_pkg::REQ_LINE, 0, 0, 0, 0, 0, 0, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 8'h01},
    '{'{mfb_pkg::REQ_LINE, 127, 63, 127, 63, 0, 0, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023}, 1'b1, 8'h80},
    // long diagonals, horizontal and vertical lines
    '{'{mfb_pkg::REQ_LINE, 0, 0, 127, 63, 0, 0, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_LINE, 127, 0, 0, 63, 0, 0, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_LINE, 5, 10, 120, 10, 0, 0, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_LINE, 64, 63, 64, 0, 0, 0, 0, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 516}, 1'b0, 8'h00},
    // zero-size and thin rectangles
    '{'{mfb_pkg::REQ_RECT, 10, 10, 0, 0, 0, 5, 1, 1, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_RECT, 10, 10, 0, 0, 5, 0, 1, 1, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_RECT, 20, 30, 0, 0, 1, 2, 1, 1, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 163}, 1'b0, 8'h00},
    // oversized outline running off the panel
    '{'{mfb_pkg::REQ_RECT, 100, 50, 0, 0, 255, 127, 1, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 806}, 1'b0, 8'h00},
    // full-panel solid clear, then a solid box with a cleared outline inside
    '{'{mfb_pkg::REQ_RECT, 0, 0, 0, 0, 128, 64, 0, 1, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_RECT, 30, 20, 0, 0, 20, 12, 1, 1, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_RECT, 33, 22, 0, 0, 14, 8, 0, 0, 0}, 1'b1, 8'h00},
    '{'{mfb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 266}, 1'b0, 8'h00}
  };

  // ---------------------------------------------------------------
  // Frame store predictor
  // ---------------------------------------------------------------
  function automatic void plot_pixel(int x, int y, bit on);
    int unsigned idx;
    logic [7:0]  bit_mask;
    if (x < 0 || y < 0 || x >= int'(FB_COLS) || y >= int'(FB_PAGES * 8)) return;
    idx      = (x * 8 + (y >> 3)) & (mfb_pkg::STORE_DEPTH - 1);
    bit_mask = 8'd1 << (y & mfb_pkg::ROW_BITS);
    if (on) frame_model[idx] = frame_model[idx] | bit_mask;
    else    frame_model[idx] = frame_model[idx] & ~bit_mask;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, bit on);
    int dx, dy, sx, sy, err, e2;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    forever begin
      plot_pixel(x0, y0, on);
      if (x0 == x1 && y0 == y1) break;
      e2 = err * 2;
      if (e2 > -dy) begin
        err -= dy;
        x0  += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y0  += sy;
      end
    end
  endfunction

  function automatic void paint_box(int left, int top, int w, int h, bit on, bit solid);
    if (w <= 0 || h <= 0) return;
    if (solid) begin
      for (int x = left; x < left + w; x++)
        for (int y = top; y < top + h; y++)
          plot_pixel(x, y, on);
      return;
    end
    for (int x = left; x < left + w; x++) begin
      plot_pixel(x, top, on);
      plot_pixel(x, top + h - 1, on);
    end
    for (int y = top; y < top + h; y++) begin
      plot_pixel(left, y, on);
      plot_pixel(left + w - 1, y, on);
    end
  endfunction

  // Apply one request to the shadow store; returns the read_data it yields
  function automatic logic [7:0] apply_request(draw_req_t r);
    logic [7:0] data;
    data = 8'h00;
    case (r.kind)
      mfb_pkg::REQ_LINE: trace_line(int'(r.xa), int'(r.ya), int'(r.xb), int'(r.yb), r.color);
      mfb_pkg::REQ_RECT: paint_box(int'(r.xa), int'(r.ya), int'(r.bw), int'(r.bh),
                                   r.color, r.solid);
      mfb_pkg::REQ_FILL: begin
        for (int x = 0; x < int'(FB_COLS); x++)
          for (int y = 0; y < int'(FB_PAGES * 8); y++)
            plot_pixel(x, y, r.color);
      end
      default:  data = frame_model[r.addr];
    endcase
    return data;
  endfunction

  // Mostly short gaps, a few long ones, none in a steady stretch
  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Random request: reads often target the last drawn spot, boxes stay small but for up to BIG_BOX_BUDGET big ones
  function automatic draw_req_t random_request();
    draw_req_t r;
    int        pick;
    r.xa    = 7'($urandom_range(0, 127));
    r.ya    = 6'($urandom_range(0, 63));
    r.xb    = 7'($urandom_range(0, 127));
    r.yb    = 6'($urandom_range(0, 63));
    r.bw    = 8'($urandom_range(0, 16));
    r.bh    = 7'($urandom_range(0, 16));
    r.color = ($urandom_range(0, 3) != 0);
    r.solid = 1'($urandom_range(0, 1));
    r.addr  = 10'($urandom_range(0, 1023));
    pick    = $urandom_range(0, 99);
    if (pick < 35) begin
      r.kind = mfb_pkg::REQ_READ;
      if ($urandom_range(0, 1))
        r.addr = 10'((last_x * 8 + (last_y >> 3)) & (mfb_pkg::STORE_DEPTH - 1));
    end else if (pick < 65) begin
      r.kind = mfb_pkg::REQ_LINE;
      if ($urandom_range(0, 2) == 0) begin
        r.xb = r.xa + 7'($urandom_range(0, 15));
        r.yb = r.ya + 6'($urandom_range(0, 15));
      end
    end else if (pick < 94) begin
      r.kind = mfb_pkg::REQ_RECT;
      if (big_boxes_left > 0 && $urandom_range(0, 99) == 0) begin
        big_boxes_left--;
        r.bw = 8'($urandom_range(100, 255));
        r.bh = 7'($urandom_range(40, 127));
      end
    end else begin
      r.kind  = mfb_pkg::REQ_FILL;
      r.color = 1'($urandom_range(0, 1));
    end
    if (r.kind == mfb_pkg::REQ_LINE || r.kind == mfb_pkg::REQ_RECT) begin
      last_x = ($urandom_range(0, 1) && r.kind == mfb_pkg::REQ_LINE) ? int'(r.xb)
                                                                   : int'(r.xa);
      last_y = (last_x == int'(r.xb) && r.kind == mfb_pkg::REQ_LINE) ? int'(r.yb)
                                                                     : int'(r.ya);
    end
    return r;
  endfunction

  // Drive one request word and record its expected read_data on acceptance
  task automatic push_request(draw_req_t w, logic fixed, logic [7:0] lit);
    int         gap;
    logic [7:0] predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= w.kind;
    req_bus.x_a          <= w.xa;
    req_bus.y_a          <= w.ya;
    req_bus.x_b          <= w.xb;
    req_bus.y_b          <= w.yb;
    req_bus.box_width    <= w.bw;
    req_bus.box_height   <= w.bh;
    req_bus.color        <= w.color;
    req_bus.fill_inside  <= w.solid;
    req_bus.read_address <= w.addr;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predicted = apply_request(w);
    pending_bytes.push_back(fixed ? lit : predicted);
  endtask

  // Response side: random stalls on ready, compare each accepted word
  always @(posedge clk_i) begin : rsp_side
    logic [7:0] want_byte;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: read_data word with none expected, expected none, actual %02h",
                 $time, rsp_bus.read_data);
        mismatch_count++;
      end else begin
        want_byte = pending_bytes.pop_front();
        if (rsp_bus.read_data !== want_byte) begin
          $display("%0t: read_data mismatch, expected %02h, actual %02h",
                   $time, want_byte, rsp_bus.read_data);
          mismatch_count++;
        end
      end
    end
    if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0 && pick_gap() > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= pick_gap();
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Stimulus, drain and verdict
  initial begin
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = mfb_pkg::REQ_READ;
    req_bus.x_a          = '0;
    req_bus.y_a          = '0;
    req_bus.x_b          = '0;
    req_bus.y_b          = '0;
    req_bus.box_width    = '0;
    req_bus.box_height   = '0;
    req_bus.color        = 1'b0;
    req_bus.fill_inside  = 1'b0;
    req_bus.read_address = '0;
    rsp_bus.ready        = 1'b0;
    for (int i = 0; i < int'(mfb_pkg::STORE_DEPTH); i++) frame_model[i] = 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_rows[i])
      push_request(script_rows[i].req, script_rows[i].fixed, script_rows[i].lit);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 150 == 0) steady_phase <= ($urandom_range(0, 2) == 0);
      push_request(random_request(), 1'b0, 8'h00);
    end
    req_bus.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("mono_framebuffer_draw_engine regression: pass");
    end else begin
      $display("mono_framebuffer_draw_engine regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("mono_framebuffer_draw_engine regression: fail");
    $finish;
  end

endmodule
